@@ rtl/ptli_pkg.sv @@
package ptli_pkg;

    localparam int TIME_FRAC_BITS = 32;
    localparam int TIME_W         = 16 + TIME_FRAC_BITS;
    localparam int DATE_W         = 17;
    localparam int MAG_W          = TIME_W + 1;
    localparam int DAYS_W         = DATE_W;
    localparam int PROD_W         = MAG_W + DAYS_W;
    localparam int CNT_REG_W      = 9;

    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_BEFORE = 3'd1;
    localparam logic [2:0] ST_FEW    = 3'd2;
    localparam logic [2:0] ST_DUP    = 3'd3;
    localparam logic [2:0] ST_FIRST  = 3'd4;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef struct packed {
        logic                     operation;
        logic [7:0]               entry_index;
        logic [DATE_W-1:0]        entry_date;
        logic signed [TIME_W-1:0] entry_time;
        logic [DATE_W-1:0]        date_start;
        logic [DATE_W-1:0]        date_end;
    } t_in_item;

    typedef struct packed {
        logic signed [TIME_W-1:0] year_fraction;
        logic [2:0]               status;
    } t_out_item;

endpackage

@@ rtl/ptli_muldiv.sv @@
// Unsigned mag * days / span, truncated; a quotient of 2^MAG_W or more is capped at 2^TIME_W.
// Shift-add multiply one bit a cycle, then restoring divide one bit a cycle.
module ptli_muldiv (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [ptli_pkg::MAG_W-1:0]    i_mag,
    input  logic [ptli_pkg::DAYS_W-1:0]   i_days,
    input  logic [ptli_pkg::DATE_W-1:0]   i_span,
    output logic                          o_done,
    output logic [ptli_pkg::MAG_W-1:0]    o_quot
);

    localparam int MW = ptli_pkg::MAG_W;
    localparam int DW = ptli_pkg::DAYS_W;
    localparam int PW = ptli_pkg::PROD_W;
    localparam int SW = ptli_pkg::DATE_W;

    typedef enum logic [1:0] {M_IDLE, M_MUL, M_DIV, M_DONE} t_mstate;

    t_mstate          r_state;
    logic [PW-1:0]    r_acc;
    logic [MW-1:0]    r_mag;
    logic [DW-1:0]    r_days;
    logic [SW-1:0]    r_span;
    logic [SW-1:0]    r_rem;
    logic [MW-1:0]    r_quot;
    logic [5:0]       r_step;
    logic [SW:0]      w_trial;
    logic [PW-1:0]    w_acc_next;

    // one multiply step and one divide step
    always_comb begin
        w_acc_next = {r_acc[PW-2:0], 1'b0} + (r_days[DW-1] ? PW'(r_mag) : '0);
        w_trial    = {r_rem, r_acc[MW-1]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= M_IDLE;
            r_step  <= '0;
        end else begin
            case (r_state)
                M_IDLE: begin
                    if (i_start) begin
                        r_mag   <= i_mag;
                        r_days  <= i_days;
                        r_span  <= i_span;
                        r_acc   <= '0;
                        r_step  <= 6'(DW - 1);
                        r_state <= M_MUL;
                    end
                end
                M_MUL: begin
                    r_acc  <= w_acc_next;
                    r_days <= {r_days[DW-2:0], 1'b0};
                    if (r_step == '0) begin
                        // quotient at or above 2^MW only needs the cap
                        if (w_acc_next[PW-1:MW] >= r_span) begin
                            r_quot  <= MW'(1) << (MW - 1);
                            r_state <= M_DONE;
                        end else begin
                            r_rem   <= w_acc_next[PW-1:MW];
                            r_quot  <= '0;
                            r_step  <= 6'(MW - 1);
                            r_state <= M_DIV;
                        end
                    end else begin
                        r_step <= r_step - 6'd1;
                    end
                end
                M_DIV: begin
                    r_acc <= {r_acc[PW-2:0], 1'b0};
                    if (w_trial >= {1'b0, r_span}) begin
                        r_rem  <= SW'(w_trial - {1'b0, r_span});
                        r_quot <= {r_quot[MW-2:0], 1'b1};
                    end else begin
                        r_rem  <= w_trial[SW-1:0];
                        r_quot <= {r_quot[MW-2:0], 1'b0};
                    end
                    if (r_step == '0) begin
                        r_state <= M_DONE;
                    end else begin
                        r_step <= r_step - 6'd1;
                    end
                end
                M_DONE: begin
                    r_state <= M_IDLE;
                end
                default: begin
                    r_state <= M_IDLE;
                end
            endcase
        end
    end

    assign o_done = (r_state == M_DONE);
    assign o_quot = r_quot;

endmodule

@@ rtl/pillar_table_linear_interpolator.sv @@
// A load item gives its result in the cycle after acceptance.
// A query runs, per date, a binary search with one table read per step, the segment
// setup states S_SEG_A, S_SEG_B and S_SEG_C, then the shared multiply/divide unit.
// Throughput: one item at a time; the next item is taken the cycle after the result leaves.
// Reset (synchronous, active low) clears control and the pillar count; the table is not cleared.
module pillar_table_linear_interpolator #(
    parameter int MAX_PILLARS = 256
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [ptli_pkg::CNT_REG_W-1:0]      i_cfg_wdata,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  ptli_pkg::t_in_item                  i_in_item,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output ptli_pkg::t_out_item                 o_out_item
);

    localparam int TW = ptli_pkg::TIME_W;
    localparam int DW = ptli_pkg::DATE_W;
    localparam int MW = ptli_pkg::MAG_W;
    localparam int AW = (MAX_PILLARS > 2) ? $clog2(MAX_PILLARS) : 1;
    localparam int CW = $clog2(MAX_PILLARS + 1);
    localparam int XW = (CW > ptli_pkg::CNT_REG_W) ? CW : ptli_pkg::CNT_REG_W;

    typedef enum logic [3:0] {
        S_IDLE, S_FIRST, S_SRCH, S_SRCH_W, S_SEG_A, S_SEG_Z,
        S_SEG_B, S_SEG_C, S_MD, S_OUT
    } t_state;

    t_state                  r_state;
    logic [ptli_pkg::CNT_REG_W-1:0] r_pillar_count;
    logic [CW-1:0]           r_n;
    logic [CW-1:0]           r_lo;
    logic [CW-1:0]           r_cnt;
    logic [CW-1:0]           r_idx;
    logic                    r_phase;
    logic [DW-1:0]           r_d_cur;
    logic [DW-1:0]           r_d_end;
    logic [DW-1:0]           r_d1;
    logic signed [TW-1:0]    r_t1;
    logic signed [TW-1:0]    r_t0;
    logic                    r_neg;
    logic signed [TW-1:0]    r_t_start;
    ptli_pkg::t_out_item     r_out;

    logic [DW-1:0]           r_dates [MAX_PILLARS];
    logic [TW-1:0]           r_times [MAX_PILLARS];
    logic [DW-1:0]           r_date_rd;
    logic signed [TW-1:0]    r_time_rd;

    logic [XW-1:0]           w_cnt_x;
    logic [CW-1:0]           w_n;
    logic [CW-1:0]           w_half;
    logic [CW-1:0]           w_mid;
    logic [CW-1:0]           w_idx;
    logic [AW-1:0]           w_raddr;
    logic                    w_we;
    logic                    w_accept;
    logic [DW:0]             w_span;
    logic [DW:0]             w_days;
    logic signed [MW-1:0]    w_diff;
    logic [MW-1:0]           w_mag;
    logic [DW-1:0]           w_days_mag;
    logic                    w_md_start;
    logic                    w_md_done;
    logic [MW-1:0]           w_md_quot;
    logic [MW-1:0]           w_q_lim;
    logic signed [TW+1:0]    w_sum;
    logic signed [TW-1:0]    w_t_map;
    logic signed [MW-1:0]    w_frac_full;

    function automatic logic signed [TW-1:0] sat_time(input logic signed [TW+1:0] v);
        logic signed [TW-1:0] res;
        if (v[TW+1:TW-1] != 3'b000 && v[TW+1:TW-1] != 3'b111) begin
            res = v[TW+1] ? {1'b1, {(TW-1){1'b0}}} : {1'b0, {(TW-1){1'b1}}};
        end else begin
            res = v[TW-1:0];
        end
        return res;
    endfunction

    // effective pillar count and search arithmetic
    always_comb begin
        w_cnt_x = XW'(r_pillar_count);
        w_n     = (w_cnt_x >= XW'(MAX_PILLARS)) ? CW'(MAX_PILLARS) : CW'(w_cnt_x);
        w_half  = r_cnt >> 1;
        w_mid   = r_lo + w_half;
        w_idx   = (r_lo >= r_n) ? (r_n - CW'(1)) : r_lo;
    end

    // table read address by state
    always_comb begin
        case (r_state)
            S_SRCH:  w_raddr = AW'(w_mid);
            S_SEG_A: w_raddr = (r_lo == '0) ? '0 : AW'(w_idx);
            S_SEG_B: w_raddr = AW'(r_idx - CW'(1));
            default: w_raddr = '0;
        endcase
    end

    assign w_accept = i_in_valid && o_in_ready;
    assign w_we     = w_accept && (i_in_item.operation == ptli_pkg::OP_LOAD)
                      && (int'(i_in_item.entry_index) < MAX_PILLARS);

    // table storage, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_dates[AW'(i_in_item.entry_index)] <= i_in_item.entry_date;
            r_times[AW'(i_in_item.entry_index)] <= i_in_item.entry_time;
        end
        r_date_rd <= r_dates[w_raddr];
        r_time_rd <= r_times[w_raddr];
    end

    // segment setup for the multiply/divide unit
    always_comb begin
        w_span     = {1'b0, r_d1} - {1'b0, r_date_rd};
        w_days     = {1'b0, r_d_cur} - {1'b0, r_date_rd};
        w_diff     = MW'(r_t1) - MW'(r_time_rd);
        w_mag      = w_diff[MW-1] ? MW'(-w_diff) : MW'(w_diff);
        w_days_mag = w_days[DW] ? DW'(-w_days) : w_days[DW-1:0];
        w_md_start = (r_state == S_SEG_C) && !w_span[DW] && (w_span != '0);
    end

    ptli_muldiv u_muldiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_md_start),
        .i_mag   (w_mag),
        .i_days  (w_days_mag),
        .i_span  (w_span[DW-1:0]),
        .o_done  (w_md_done),
        .o_quot  (w_md_quot)
    );

    // mapped time and final difference
    always_comb begin
        // clamp the quotient at 2^TW; any larger value saturates the same way
        w_q_lim = w_md_quot[MW-1] ? (MW'(1) << (MW - 1)) : w_md_quot;
        w_sum = r_neg ? ((TW+2)'(r_t0) - (TW+2)'(w_q_lim))
                      : ((TW+2)'(r_t0) + (TW+2)'(w_q_lim));
        w_t_map     = (r_state == S_SEG_Z) ? '0 : sat_time(w_sum);
        w_frac_full = MW'(w_t_map) - MW'(r_t_start);
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_pillar_count <= '0;
            r_phase        <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_pillar_count <= i_cfg_wdata;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_out.year_fraction <= '0;
                        r_out.status        <= ((i_in_item.operation == ptli_pkg::OP_QUERY)
                                                && (w_n < CW'(2)))
                                               ? ptli_pkg::ST_FEW : ptli_pkg::ST_OK;
                        r_n                 <= w_n;
                        r_d_cur             <= i_in_item.date_start;
                        r_d_end             <= i_in_item.date_end;
                        r_phase             <= 1'b0;
                        if (i_in_item.operation == ptli_pkg::OP_LOAD) begin
                            r_state <= S_OUT;
                        end else if (w_n < CW'(2)) begin
                            r_state <= S_OUT;
                        end else begin
                            r_state <= S_FIRST;
                        end
                    end
                end
                S_FIRST: begin
                    if (r_time_rd != '0) begin
                        r_out.status <= ptli_pkg::ST_FIRST;
                        r_state      <= S_OUT;
                    end else begin
                        r_lo    <= '0;
                        r_cnt   <= r_n;
                        r_state <= S_SRCH;
                    end
                end
                S_SRCH: begin
                    r_state <= (r_cnt == '0) ? S_SEG_A : S_SRCH_W;
                end
                S_SRCH_W: begin
                    // lower bound: move past pillars earlier than the date
                    if (r_date_rd < r_d_cur) begin
                        r_lo  <= w_mid + CW'(1);
                        r_cnt <= r_cnt - w_half - CW'(1);
                    end else begin
                        r_cnt <= w_half;
                    end
                    r_state <= S_SRCH;
                end
                S_SEG_A: begin
                    r_idx   <= w_idx;
                    r_state <= (r_lo == '0) ? S_SEG_Z : S_SEG_B;
                end
                S_SEG_Z: begin
                    if (r_date_rd != r_d_cur) begin
                        r_out.status <= ptli_pkg::ST_BEFORE;
                        r_state      <= S_OUT;
                    end else if (!r_phase) begin
                        r_t_start <= w_t_map;
                        r_phase   <= 1'b1;
                        r_d_cur   <= r_d_end;
                        r_lo      <= '0;
                        r_cnt     <= r_n;
                        r_state   <= S_SRCH;
                    end else begin
                        r_out.year_fraction <= sat_time((TW+2)'(w_frac_full));
                        r_state             <= S_OUT;
                    end
                end
                S_SEG_B: begin
                    r_d1    <= r_date_rd;
                    r_t1    <= r_time_rd;
                    r_state <= S_SEG_C;
                end
                S_SEG_C: begin
                    if (w_md_start) begin
                        r_t0    <= r_time_rd;
                        r_neg   <= w_diff[MW-1] ^ w_days[DW];
                        r_state <= S_MD;
                    end else begin
                        r_out.status <= ptli_pkg::ST_DUP;
                        r_state      <= S_OUT;
                    end
                end
                S_MD: begin
                    if (w_md_done) begin
                        if (!r_phase) begin
                            r_t_start <= w_t_map;
                            r_phase   <= 1'b1;
                            r_d_cur   <= r_d_end;
                            r_lo      <= '0;
                            r_cnt     <= r_n;
                            r_state   <= S_SRCH;
                        end else begin
                            r_out.year_fraction <= sat_time((TW+2)'(w_frac_full));
                            r_state             <= S_OUT;
                        end
                    end
                end
                S_OUT: begin
                    if (i_out_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);
    assign o_out_item  = r_out;

    // never take an item while a result is held
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input ready while a result is held");

    // the divider finishes only while the sequencer waits on it
    a_md_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_md_done |-> (r_state == S_MD))
        else $error("multiply/divide done outside its wait state");

    // a failing status carries a zero fraction
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.status != ptli_pkg::ST_OK)
            |-> (o_out_item.year_fraction == '0))
        else $error("nonzero fraction with error status");

    // a taken result frees the input side next cycle
    a_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready) |=> o_in_ready)
        else $error("block not ready after result taken");

endmodule
